/* design/ipf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ipf_pkg;

    localparam int LIST_DEPTH_DEF = 64;
    localparam int CMD_Q_DEPTH    = 4;
    localparam int RES_Q_DEPTH    = 2;
    localparam int MAX_OUT        = 64;
    localparam int ADDR_W         = 32;
    localparam int IDX_W          = 6;
    localparam int CNT_W          = 7;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_CHECK  = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_CHK,
        BS_CHK_END,
        BS_CHK_OUT,
        BS_RD_ISSUE,
        BS_RD_DATA
    } t_bstate;

    typedef struct packed {
        t_op               op;
        logic              sel;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] rs;
        logic [ADDR_W-1:0] re;
        logic [IDX_W-1:0]  idx;
        logic [CNT_W-1:0]  cnt;
        logic              cnt_zero;
    } t_cmd;

    typedef struct packed {
        logic              alive;
        logic              in_allow;
        logic              in_block;
        logic [ADDR_W-1:0] entry_start;
        logic [ADDR_W-1:0] entry_end;
        logic [CNT_W-1:0]  returned_count;
        t_status           status;
        logic              last;
    } t_res;

endpackage

`default_nettype wire

/* design/ipf_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module ipf_ram #(
    parameter int W     = 64,
    parameter int DEPTH = ipf_pkg::LIST_DEPTH_DEF
) (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [W-1:0]                                   i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [W-1:0]                                   o_rdata
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* design/ipf_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module ipf_fifo #(
    parameter int W     = 1,
    parameter int DEPTH = ipf_pkg::RES_Q_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic      [W-1:0] o_data,
    output logic              o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* design/ipf_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module ipf_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    output logic                             o_full,
    input  wire logic [1:0]                  i_func,
    input  wire logic                        i_list_select,
    input  wire logic [ipf_pkg::ADDR_W-1:0]  i_address,
    input  wire logic [ipf_pkg::ADDR_W-1:0]  i_range_start,
    input  wire logic [ipf_pkg::ADDR_W-1:0]  i_range_end,
    input  wire logic [ipf_pkg::IDX_W-1:0]   i_index,
    input  wire logic [ipf_pkg::CNT_W-1:0]   i_count,
    output ipf_pkg::t_cmd                    o_cmd,
    output logic                             o_cmd_empty,
    input  wire logic                        i_cmd_pop
);

    localparam int QW = $bits(ipf_pkg::t_cmd);

    ipf_pkg::t_cmd cmd_in;
    logic [QW-1:0] q_out;

    always_comb begin
        cmd_in          = '0;
        cmd_in.op       = ipf_pkg::t_op'(i_func);
        cmd_in.sel      = i_list_select;
        cmd_in.addr     = i_address;
        cmd_in.rs       = i_range_start;
        cmd_in.re       = i_range_end;
        cmd_in.idx      = i_index;
        cmd_in.cnt      = i_count;
        cmd_in.cnt_zero = (i_count == '0);
    end

    ipf_fifo #(
        .W     (QW),
        .DEPTH (ipf_pkg::CMD_Q_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (QW'(cmd_in)),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (q_out),
        .o_empty (o_cmd_empty)
    );

    assign o_cmd = ipf_pkg::t_cmd'(q_out);

endmodule

`default_nettype wire

/* design/ipf_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module ipf_back #(
    parameter int LIST_DEPTH = ipf_pkg::LIST_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ipf_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_empty,
    output logic               o_cmd_pop,
    output ipf_pkg::t_res      o_res,
    output logic               o_res_empty,
    input  wire logic          i_res_pop
);

    localparam int AW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int UW  = $clog2(LIST_DEPTH + 1);
    localparam int NW  = ipf_pkg::CNT_W;
    localparam int CW  = (UW > NW) ? UW : NW;
    localparam int DW  = ipf_pkg::ADDR_W;
    localparam int EW  = 2 * DW;
    localparam int RW  = $bits(ipf_pkg::t_res);

    ipf_pkg::t_bstate r_state, n_state;
    logic [UW-1:0]    r_used_a, n_used_a;
    logic [UW-1:0]    r_used_b, n_used_b;
    logic [UW-1:0]    r_ptr, n_ptr;
    logic             r_pa, n_pa;
    logic             r_pb, n_pb;
    logic             r_hit_a, n_hit_a;
    logic             r_hit_b, n_hit_b;
    logic [DW-1:0]    r_addr, n_addr;
    logic             r_sel, n_sel;
    logic [NW-1:0]    r_n, n_n;
    logic [NW-1:0]    r_left, n_left;

    logic [UW-1:0]    cmd_used;
    logic [UW-1:0]    max_used;
    logic [UW-1:0]    ptr_inc;
    logic             append_full;
    logic             read_none;
    logic [CW-1:0]    avail;
    logic [CW-1:0]    min1;
    logic [NW-1:0]    rd_n;
    logic [EW-1:0]    rd_a, rd_b, sel_data;
    logic             hit_a_now, hit_b_now;
    logic             we_a, we_b;
    logic             res_push, res_full;
    ipf_pkg::t_res    res;
    logic [RW-1:0]    res_q;

    assign cmd_used    = i_cmd.sel ? r_used_b : r_used_a;
    assign max_used    = (r_used_a > r_used_b) ? r_used_a : r_used_b;
    assign ptr_inc     = r_ptr + UW'(1);
    assign append_full = (cmd_used == UW'(LIST_DEPTH));
    assign read_none   = i_cmd.cnt_zero || (CW'(i_cmd.idx) >= CW'(cmd_used));
    assign avail       = CW'(cmd_used) - CW'(i_cmd.idx);
    assign min1        = (CW'(i_cmd.cnt) < avail) ? CW'(i_cmd.cnt) : avail;
    assign rd_n        = (min1 > CW'(ipf_pkg::MAX_OUT)) ? NW'(ipf_pkg::MAX_OUT) : NW'(min1);
    assign sel_data    = r_sel ? rd_b : rd_a;
    assign hit_a_now   = r_pa && (rd_a[EW-1:DW] <= r_addr) && (r_addr <= rd_a[DW-1:0]);
    assign hit_b_now   = r_pb && (rd_b[EW-1:DW] <= r_addr) && (r_addr <= rd_b[DW-1:0]);

    ipf_ram #(.W(EW), .DEPTH(LIST_DEPTH)) u_allow_ram (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (cmd_used[AW-1:0]),
        .i_wdata ({i_cmd.rs, i_cmd.re}),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (rd_a)
    );

    ipf_ram #(.W(EW), .DEPTH(LIST_DEPTH)) u_block_ram (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (cmd_used[AW-1:0]),
        .i_wdata ({i_cmd.rs, i_cmd.re}),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (rd_b)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ipf_pkg::BS_IDLE: begin
                if (!i_cmd_empty) begin
                    unique case (i_cmd.op)
                        ipf_pkg::OP_CHECK: begin
                            n_state = (max_used == '0) ? ipf_pkg::BS_CHK_OUT : ipf_pkg::BS_CHK;
                        end
                        ipf_pkg::OP_READ: begin
                            if (!read_none) begin
                                n_state = ipf_pkg::BS_RD_ISSUE;
                            end
                        end
                        ipf_pkg::OP_APPEND, ipf_pkg::OP_CLEAR: begin
                            n_state = ipf_pkg::BS_IDLE;
                        end
                    endcase
                end
            end
            ipf_pkg::BS_CHK: begin
                if (ptr_inc >= max_used) begin
                    n_state = ipf_pkg::BS_CHK_END;
                end
            end
            ipf_pkg::BS_CHK_END: begin
                n_state = ipf_pkg::BS_CHK_OUT;
            end
            ipf_pkg::BS_CHK_OUT: begin
                if (!res_full) begin
                    n_state = ipf_pkg::BS_IDLE;
                end
            end
            ipf_pkg::BS_RD_ISSUE: begin
                if (!res_full) begin
                    n_state = ipf_pkg::BS_RD_DATA;
                end
            end
            ipf_pkg::BS_RD_DATA: begin
                n_state = (r_left == NW'(1)) ? ipf_pkg::BS_IDLE : ipf_pkg::BS_RD_ISSUE;
            end
            default: begin
                n_state = ipf_pkg::BS_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd_pop  = 1'b0;
        res_push   = 1'b0;
        we_a       = 1'b0;
        we_b       = 1'b0;
        res        = '0;
        res.status = ipf_pkg::ST_OK;
        unique case (r_state)
            ipf_pkg::BS_IDLE: begin
                if (!i_cmd_empty) begin
                    unique case (i_cmd.op)
                        ipf_pkg::OP_APPEND: begin
                            if (!res_full) begin
                                o_cmd_pop = 1'b1;
                                res_push  = 1'b1;
                                res.last  = 1'b1;
                                if (append_full) begin
                                    res.status = ipf_pkg::ST_FULL;
                                end else begin
                                    we_a = !i_cmd.sel;
                                    we_b = i_cmd.sel;
                                end
                            end
                        end
                        ipf_pkg::OP_CLEAR: begin
                            if (!res_full) begin
                                o_cmd_pop = 1'b1;
                                res_push  = 1'b1;
                                res.last  = 1'b1;
                            end
                        end
                        ipf_pkg::OP_CHECK: begin
                            o_cmd_pop = 1'b1;
                        end
                        ipf_pkg::OP_READ: begin
                            if (read_none) begin
                                if (!res_full) begin
                                    o_cmd_pop  = 1'b1;
                                    res_push   = 1'b1;
                                    res.status = ipf_pkg::ST_EMPTY;
                                    res.last   = 1'b1;
                                end
                            end else begin
                                o_cmd_pop = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ipf_pkg::BS_CHK_OUT: begin
                if (!res_full) begin
                    res_push     = 1'b1;
                    res.alive    = r_hit_a && !r_hit_b;
                    res.in_allow = r_hit_a;
                    res.in_block = r_hit_b;
                    res.last     = 1'b1;
                end
            end
            ipf_pkg::BS_RD_DATA: begin
                res_push           = 1'b1;
                res.entry_start    = sel_data[EW-1:DW];
                res.entry_end      = sel_data[DW-1:0];
                res.returned_count = r_n;
                res.last           = (r_left == NW'(1));
            end
            ipf_pkg::BS_CHK, ipf_pkg::BS_CHK_END, ipf_pkg::BS_RD_ISSUE: begin
                res_push = 1'b0;
            end
            default: begin
                res_push = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        n_used_a = r_used_a;
        n_used_b = r_used_b;
        n_ptr    = r_ptr;
        n_pa     = 1'b0;
        n_pb     = 1'b0;
        n_hit_a  = r_hit_a || hit_a_now;
        n_hit_b  = r_hit_b || hit_b_now;
        n_addr   = r_addr;
        n_sel    = r_sel;
        n_n      = r_n;
        n_left   = r_left;
        case (r_state)
            ipf_pkg::BS_IDLE: begin
                if (o_cmd_pop) begin
                    case (i_cmd.op)
                        ipf_pkg::OP_APPEND: begin
                            if (!append_full) begin
                                if (i_cmd.sel) begin
                                    n_used_b = r_used_b + UW'(1);
                                end else begin
                                    n_used_a = r_used_a + UW'(1);
                                end
                            end
                        end
                        ipf_pkg::OP_CLEAR: begin
                            if (i_cmd.sel) begin
                                n_used_b = '0;
                            end else begin
                                n_used_a = '0;
                            end
                        end
                        ipf_pkg::OP_CHECK: begin
                            n_addr  = i_cmd.addr;
                            n_hit_a = 1'b0;
                            n_hit_b = 1'b0;
                            n_ptr   = '0;
                        end
                        default: begin
                            n_sel  = i_cmd.sel;
                            n_ptr  = UW'(i_cmd.idx);
                            n_n    = rd_n;
                            n_left = rd_n;
                        end
                    endcase
                end
            end
            ipf_pkg::BS_CHK: begin
                n_pa  = (r_ptr < r_used_a);
                n_pb  = (r_ptr < r_used_b);
                n_ptr = ptr_inc;
            end
            ipf_pkg::BS_RD_DATA: begin
                n_ptr  = ptr_inc;
                n_left = r_left - NW'(1);
            end
            default: begin
                n_ptr = r_ptr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ipf_pkg::BS_IDLE;
            r_used_a <= '0;
            r_used_b <= '0;
            r_pa     <= 1'b0;
            r_pb     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used_a <= n_used_a;
            r_used_b <= n_used_b;
            r_pa     <= n_pa;
            r_pb     <= n_pb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_hit_a <= n_hit_a;
        r_hit_b <= n_hit_b;
        r_addr  <= n_addr;
        r_sel   <= n_sel;
        r_n     <= n_n;
        r_left  <= n_left;
    end

    ipf_fifo #(
        .W     (RW),
        .DEPTH (ipf_pkg::RES_Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (RW'(res)),
        .o_full  (res_full),
        .i_pop   (i_res_pop),
        .o_data  (res_q),
        .o_empty (o_res_empty)
    );

    assign o_res = ipf_pkg::t_res'(res_q);

    a_used_a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used_a <= UW'(LIST_DEPTH))
        else $error("allow count past depth");

    a_used_b_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used_b <= UW'(LIST_DEPTH))
        else $error("block count past depth");

    a_rd_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ipf_pkg::BS_RD_DATA) |-> !res_full)
        else $error("read entry with no room in result queue");

    a_rd_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ipf_pkg::BS_RD_ISSUE || r_state == ipf_pkg::BS_RD_DATA)
            |-> (r_left != '0))
        else $error("read burst with zero entries left");

    a_chk_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pa || r_pb) |-> (r_state == ipf_pkg::BS_CHK || r_state == ipf_pkg::BS_CHK_END))
        else $error("list probe outside a check");

endmodule

`default_nettype wire

/* design/ip_range_allow_block_filter.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// input     in         push / full        func, list_select, address, range_start,
//                                         range_end, index, count
// result    out        empty / pop        alive, in_allow, in_block, entry_start,
//                                         entry_end, returned_count, status, last
//
// Items enter a command queue at one per cycle while it has room.
// Append and clear finish in the idle state once the result queue has room; a check
// scans both range RAMs one entry per cycle over max(allow used, block used) entries
// (no scan with both lists empty); a read does a RAM read, then a result push, per
// entry. Synchronous reset empties both lists; no RAM sweep. Either side may stall:
// full rises when the command queue fills, results wait in a small output queue.

module ip_range_allow_block_filter #(
    parameter int LIST_DEPTH = ipf_pkg::LIST_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [1:0]                 i_func,
    input  wire logic                       i_list_select,
    input  wire logic [ipf_pkg::ADDR_W-1:0] i_address,
    input  wire logic [ipf_pkg::ADDR_W-1:0] i_range_start,
    input  wire logic [ipf_pkg::ADDR_W-1:0] i_range_end,
    input  wire logic [ipf_pkg::IDX_W-1:0]  i_index,
    input  wire logic [ipf_pkg::CNT_W-1:0]  i_count,
    output logic                            empty,
    input  wire logic                       pop,
    output logic                            o_alive,
    output logic                            o_in_allow,
    output logic                            o_in_block,
    output logic [ipf_pkg::ADDR_W-1:0]      o_entry_start,
    output logic [ipf_pkg::ADDR_W-1:0]      o_entry_end,
    output logic [ipf_pkg::CNT_W-1:0]       o_returned_count,
    output logic [1:0]                      o_status,
    output logic                            o_last
);

    ipf_pkg::t_cmd cmd;
    logic          cmd_empty;
    logic          cmd_pop;
    ipf_pkg::t_res res;

    ipf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_func        (i_func),
        .i_list_select (i_list_select),
        .i_address     (i_address),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .i_index       (i_index),
        .i_count       (i_count),
        .o_cmd         (cmd),
        .o_cmd_empty   (cmd_empty),
        .i_cmd_pop     (cmd_pop)
    );

    ipf_back #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res       (res),
        .o_res_empty (empty),
        .i_res_pop   (pop)
    );

    assign o_alive          = res.alive;
    assign o_in_allow       = res.in_allow;
    assign o_in_block       = res.in_block;
    assign o_entry_start    = res.entry_start;
    assign o_entry_end      = res.entry_end;
    assign o_returned_count = res.returned_count;
    assign o_status         = res.status;
    assign o_last           = res.last;

endmodule

`default_nettype wire
